[sv/gmv_pkg.sv]
// Shared types and constants for the grouped mean and variance core.
// Used by gmv_cell, gmv_stats and grouped_mean_variance_core; no dependencies.
package gmv_pkg;

    localparam int KEY_W   = 32;
    localparam int SAMP_W  = 16;
    localparam int SQ1_W   = 32;
    localparam int SUM_W   = 40;
    localparam int SQS_W   = 56;
    localparam int CNT_W   = 21;
    localparam int STAT_W  = 32;
    localparam int RD_W    = 3;
    localparam int POW_W   = 14;

    // Input transaction kinds.
    localparam logic [1:0] KIND_ACC    = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // One class entry held by a cell.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SUM_W-1:0]        sum;
        logic [SQS_W-1:0]        sq;
        logic [CNT_W-1:0]        cnt;
    } entry_t;

    // Link handed from a cell to its right-hand neighbour.
    typedef struct packed {
        logic occ;
        logic gt;
    } link_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                     update;
        logic                     insert;
        logic signed [KEY_W-1:0]  key;
        logic signed [SAMP_W-1:0] sample;
        logic [SQ1_W-1:0]         sq;
        logic                     sample_ok;
    } bcast_t;

    // Powers of ten for the key rounding.
    function automatic logic [POW_W-1:0] pow_ten(input logic [RD_W-1:0] d);
        logic [POW_W-1:0] p;
        begin
            case (d)
                3'd0:    p = 14'd1;
                3'd1:    p = 14'd10;
                3'd2:    p = 14'd100;
                3'd3:    p = 14'd1000;
                default: p = 14'd10000;
            endcase
            return p;
        end
    endfunction

endpackage

[sv/grouped_mean_variance_core.sv]
// Top level of the grouped mean and variance core: a chain of class cells
// kept sorted by rounded key and a shared statistics unit.
// Depends on gmv_pkg, gmv_cell and gmv_stats.
//
// Input transactions arrive on the s_ stream: tuser carries the kind and
// the missing flags, tdata the key (Q16.16) and the sample (Q8.8). Result
// transactions leave on the m_ stream, with tlast on the final result of
// an input transaction. The rounding digits register is written through
// cfg_we and cfg_wdata while the core is idle; the user must keep to
// this, as the core itself does not enforce it. One transaction is
// taken at a time. After an accumulate or clear is accepted, the core
// passes through S_ROUND and S_EXEC before it takes the next input. A
// lookup and each class of a report pass through the statistics unit,
// whose two shift-add multiplies and two 80-bit restoring divides run
// one bit per cycle; the result is registered when the unit is done.
// A miss or an empty report is registered straight from S_EXEC.
// A result is held in the output register until the receiver takes it;
// while the receiver stalls the core makes no progress and takes no input.
// Reset empties the table, clears the overflow flag and sets the rounding
// digits to four; the class cells themselves need no clearing.
module grouped_mean_variance_core #(
    parameter int MAX_CLASSES = 64,
    parameter int MAX_COUNT   = 1048576
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // key_value[31:0], sample_value[47:32]
    input  logic [3:0]   s_tuser,   // kind[1:0], key_missing[2], sample_missing[3]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // class_key[31:0], sample_count[52:32],
                                    // mean[84:53], variance[116:85], zero pad
    output logic [3:0]   m_tuser,   // mean_valid, variance_valid, found,
                                    // table_overflowed
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_wdata
);

    localparam int KEY_W = gmv_pkg::KEY_W;
    localparam int CNT_W = gmv_pkg::CNT_W;
    localparam int ST_W  = gmv_pkg::STAT_W;
    localparam int SQ1_W = gmv_pkg::SQ1_W;
    localparam int POW_W = gmv_pkg::POW_W;
    localparam int UW    = $clog2(MAX_CLASSES + 1);
    localparam int IW    = $clog2(MAX_CLASSES);
    localparam int PW    = KEY_W + POW_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_EXEC, S_SEL, S_WAIT, S_OUT
    } state_t;

    state_t                      state_reg;
    logic [2:0]                  rd_reg;
    logic [1:0]                  kind_reg;
    logic signed [KEY_W-1:0]     raw_reg;
    logic                        kmiss_reg;
    logic signed [15:0]          samp_reg;
    logic                        smiss_reg;
    logic signed [KEY_W-1:0]     key_reg;
    logic [SQ1_W-1:0]            sq_reg;
    logic [UW-1:0]               used_reg;
    logic                        ovf_reg;
    logic [IW-1:0]               idx_reg;
    logic                        start_reg;
    gmv_pkg::entry_t             sel_reg;
    logic                        lastsel_reg;
    logic                        mvalid_reg;
    logic [119:0]                mdata_reg;
    logic [3:0]                  muser_reg;
    logic                        mlast_reg;

    gmv_pkg::entry_t             entries [MAX_CLASSES];
    gmv_pkg::link_t              links   [MAX_CLASSES];
    logic [MAX_CLASSES-1:0]      match_vec;
    gmv_pkg::bcast_t             bc;
    logic                        match_any;
    logic [IW-1:0]               match_idx;
    logic                        full;

    logic [2:0]                  dig;
    logic [KEY_W-1:0]            mag;
    logic [PW-1:0]               prod;
    logic [KEY_W-1:0]            rq;
    logic signed [KEY_W-1:0]     rkey;

    logic                        st_done;
    logic [ST_W-1:0]             st_mean;
    logic [ST_W-1:0]             st_var;
    logic                        mv;
    logic                        vv;

    // Key rounding half away from zero.
    always_comb
    begin
        dig  = (rd_reg > 3'd4) ? 3'd4 : rd_reg;
        mag  = raw_reg[KEY_W-1] ? (~raw_reg + KEY_W'(1)) : raw_reg;
        prod = PW'(mag) * PW'(gmv_pkg::pow_ten(dig)) + PW'(32768);
        rq   = KEY_W'(prod >> 16);
        rkey = kmiss_reg ? '0 : (raw_reg[KEY_W-1] ? (~rq + KEY_W'(1)) : rq);
    end

    // Broadcast to the cells and the match summary.
    always_comb
    begin
        full      = (used_reg == UW'(MAX_CLASSES));
        match_any = |match_vec;
        match_idx = '0;
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            if (match_vec[i])
                match_idx = match_idx | IW'(i);
        end
        bc.key       = key_reg;
        bc.sample    = samp_reg;
        bc.sq        = sq_reg;
        bc.sample_ok = !smiss_reg;
        bc.update    = (state_reg == S_EXEC) && (kind_reg == gmv_pkg::KIND_ACC)
                       && !kmiss_reg;
        bc.insert    = bc.update && !match_any && !full;
    end

    // The chain of class cells.
    for (genvar g = 0; g < MAX_CLASSES; g++)
    begin : g_cell
        gmv_pkg::entry_t le;
        gmv_pkg::link_t  ll;
        if (g == 0)
        begin : g_head
            assign le = '0;
            assign ll = '{occ: 1'b1, gt: 1'b0};
        end
        else
        begin : g_body
            assign le = entries[g-1];
            assign ll = links[g-1];
        end
        gmv_cell #(
            .MAX_COUNT (MAX_COUNT)
        ) u_cell (
            .clk        (clk),
            .bc         (bc),
            .occ        (UW'(g) < used_reg),
            .left_entry (le),
            .left_link  (ll),
            .entry      (entries[g]),
            .link       (links[g]),
            .match      (match_vec[g])
        );
    end

    // Shared statistics unit.
    gmv_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .n        (sel_reg.cnt),
        .sum      (sel_reg.sum),
        .sq       (sel_reg.sq),
        .done     (st_done),
        .mean     (st_mean),
        .variance (st_var)
    );

    assign mv = (sel_reg.cnt >= CNT_W'(1));
    assign vv = (sel_reg.cnt >= CNT_W'(2));

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_reg <= 3'd4;
        else if (cfg_we)
            rd_reg <= cfg_wdata;
    end

    // Control sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            ovf_reg    <= 1'b0;
            start_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg  <= s_tuser[1:0];
                        kmiss_reg <= s_tuser[2];
                        smiss_reg <= s_tuser[3];
                        raw_reg   <= s_tdata[31:0];
                        samp_reg  <= s_tdata[47:32];
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    key_reg   <= rkey;
                    sq_reg    <= SQ1_W'(samp_reg * samp_reg);
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    case (kind_reg)
                        gmv_pkg::KIND_ACC:
                        begin
                            if (bc.insert)
                                used_reg <= used_reg + UW'(1);
                            else if (bc.update && !match_any)
                                ovf_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        gmv_pkg::KIND_REPORT:
                        begin
                            if (used_reg == '0)
                            begin
                                mdata_reg  <= '0;
                                muser_reg  <= {ovf_reg, 3'b000};
                                mlast_reg  <= 1'b1;
                                mvalid_reg <= 1'b1;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_SEL;
                            end
                        end
                        gmv_pkg::KIND_LOOKUP:
                        begin
                            if (kmiss_reg || !match_any)
                            begin
                                mdata_reg  <= {88'd0, key_reg};
                                muser_reg  <= {ovf_reg, 3'b000};
                                mlast_reg  <= 1'b1;
                                mvalid_reg <= 1'b1;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                idx_reg   <= match_idx;
                                state_reg <= S_SEL;
                            end
                        end
                        default:
                        begin
                            used_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SEL:
                begin
                    sel_reg     <= entries[idx_reg];
                    lastsel_reg <= (kind_reg != gmv_pkg::KIND_REPORT)
                                   || (UW'(idx_reg) + UW'(1) == used_reg);
                    start_reg   <= 1'b1;
                    state_reg   <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (st_done)
                    begin
                        mdata_reg  <= {3'b000, (vv ? st_var : {ST_W{1'b0}}),
                                       (mv ? st_mean : {ST_W{1'b0}}),
                                       sel_reg.cnt, sel_reg.key};
                        muser_reg  <= {ovf_reg, 1'b1, vv, mv};
                        mlast_reg  <= lastsel_reg;
                        mvalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        mvalid_reg <= 1'b0;
                        if (mlast_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= S_SEL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule

[sv/gmv_cell.sv]
// One cell of the sorted class table: holds a single class entry.
// Depends on gmv_pkg; instantiated as a chain by grouped_mean_variance_core.
module gmv_cell #(
    parameter int MAX_COUNT = 1048576
) (
    input  logic            clk,
    input  gmv_pkg::bcast_t bc,
    input  logic            occ,
    input  gmv_pkg::entry_t left_entry,
    input  gmv_pkg::link_t  left_link,
    output gmv_pkg::entry_t entry,
    output gmv_pkg::link_t  link,
    output logic            match
);

    localparam int SUM_W = gmv_pkg::SUM_W;
    localparam int SQS_W = gmv_pkg::SQS_W;
    localparam int CNT_W = gmv_pkg::CNT_W;

    gmv_pkg::entry_t entry_reg;
    gmv_pkg::entry_t entry_next;
    logic            gt;
    logic            place;

    // Compare the broadcast key with the stored one.
    always_comb
    begin
        gt    = occ && (entry_reg.key > bc.key);
        match = occ && (entry_reg.key == bc.key);
        place = (gt || !occ) && left_link.occ && !left_link.gt;
        link  = '{occ: occ, gt: gt};
    end

    // Open a new class here, shift the left entry in, or add the sample to this class.
    always_comb
    begin
        entry_next = entry_reg;
        if (bc.insert && place)
        begin
            entry_next.key = bc.key;
            entry_next.sum = bc.sample_ok ? SUM_W'(bc.sample) : '0;
            entry_next.sq  = bc.sample_ok ? SQS_W'(bc.sq) : '0;
            entry_next.cnt = bc.sample_ok ? CNT_W'(1) : '0;
        end
        else if (bc.insert && left_link.occ && left_link.gt)
        begin
            entry_next = left_entry;
        end
        else if (bc.update && match && bc.sample_ok
                 && (entry_reg.cnt < CNT_W'(MAX_COUNT)))
        begin
            entry_next.sum = entry_reg.sum + SUM_W'(bc.sample);
            entry_next.sq  = entry_reg.sq + SQS_W'(bc.sq);
            entry_next.cnt = entry_reg.cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[sv/gmv_stats.sv]
// Mean and unbiased variance of one class by shift-add multiplication and
// restoring division, one bit per cycle. Depends on gmv_pkg.
module gmv_stats (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gmv_pkg::CNT_W-1:0]    n,
    input  logic [gmv_pkg::SUM_W-1:0]    sum,
    input  logic [gmv_pkg::SQS_W-1:0]    sq,
    output logic                         done,
    output logic [gmv_pkg::STAT_W-1:0]   mean,
    output logic [gmv_pkg::STAT_W-1:0]   variance
);

    localparam int CNT_W = gmv_pkg::CNT_W;
    localparam int SUM_W = gmv_pkg::SUM_W;
    localparam int SQS_W = gmv_pkg::SQS_W;
    localparam int ST_W  = gmv_pkg::STAT_W;
    localparam int W     = 80;
    localparam int DEN_W = 2 * CNT_W;
    localparam int REM_W = DEN_W + 1;
    localparam int CW    = 7;

    typedef enum logic [2:0] {
        S_IDLE, S_MULN, S_MULS, S_DIVM, S_DIVV
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      step_reg;
    logic [W-1:0]       acc_reg;
    logic [W-1:0]       mcand_reg;
    logic [SUM_W-1:0]   mplier_reg;
    logic [W-1:0]       prod_reg;
    logic [W-1:0]       dvd_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   den_var_reg;
    logic [SUM_W-1:0]   asum_reg;
    logic               neg_reg;
    logic               numneg_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               done_reg;
    logic [ST_W-1:0]    mean_reg;
    logic [ST_W-1:0]    var_reg;

    logic [SUM_W-1:0]   asum_in;
    logic [W-1:0]       acc_add;
    logic [REM_W-1:0]   rem_sh;
    logic               q_bit;
    logic [REM_W-1:0]   rem_new;
    logic [W-1:0]       dvd_new;
    logic [W-1:0]       qneg;

    // Magnitude of the sum, multiply step and restoring divide step.
    always_comb
    begin
        asum_in = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
        acc_add = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
        rem_sh  = {rem_reg[REM_W-2:0], dvd_reg[W-1]};
        q_bit   = (rem_sh >= REM_W'(den_reg));
        rem_new = q_bit ? (rem_sh - REM_W'(den_reg)) : rem_sh;
        dvd_new = {dvd_reg[W-2:0], q_bit};
        qneg    = ~dvd_new + W'(1);
    end

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg       <= n;
                        asum_reg    <= asum_in;
                        neg_reg     <= sum[SUM_W-1];
                        den_var_reg <= n * (n - CNT_W'(1));
                        acc_reg     <= '0;
                        mcand_reg   <= W'(sq);
                        mplier_reg  <= SUM_W'(n);
                        step_reg    <= CW'(CNT_W);
                        state_reg   <= S_MULN;
                    end
                end
                S_MULN:
                begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[W-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    step_reg   <= step_reg - CW'(1);
                    if (step_reg == CW'(1))
                    begin
                        prod_reg   <= acc_add;
                        acc_reg    <= '0;
                        mcand_reg  <= W'(asum_reg);
                        mplier_reg <= asum_reg;
                        step_reg   <= CW'(SUM_W);
                        state_reg  <= S_MULS;
                    end
                end
                S_MULS:
                begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[W-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    step_reg   <= step_reg - CW'(1);
                    if (step_reg == CW'(1))
                    begin
                        numneg_reg <= (prod_reg < acc_add);
                        prod_reg   <= prod_reg - acc_add;
                        dvd_reg    <= W'({asum_reg, 8'h00});
                        rem_reg    <= '0;
                        den_reg    <= DEN_W'(n_reg);
                        step_reg   <= CW'(W);
                        state_reg  <= S_DIVM;
                    end
                end
                S_DIVM:
                begin
                    dvd_reg  <= dvd_new;
                    rem_reg  <= rem_new;
                    step_reg <= step_reg - CW'(1);
                    if (step_reg == CW'(1))
                    begin
                        mean_reg  <= neg_reg ? qneg[ST_W-1:0] : dvd_new[ST_W-1:0];
                        dvd_reg   <= prod_reg;
                        rem_reg   <= '0;
                        den_reg   <= den_var_reg;
                        step_reg  <= CW'(W);
                        state_reg <= S_DIVV;
                    end
                end
                S_DIVV:
                begin
                    dvd_reg  <= dvd_new;
                    rem_reg  <= rem_new;
                    step_reg <= step_reg - CW'(1);
                    if (step_reg == CW'(1))
                    begin
                        if (numneg_reg)
                            var_reg <= '0;
                        else if (dvd_new[W-1:ST_W] != '0)
                            var_reg <= '1;
                        else
                            var_reg <= dvd_new[ST_W-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign mean     = mean_reg;
    assign variance = var_reg;

endmodule
